### rtl/core/swm_pkg.sv
package swm_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int WINDOW_MAX   = 32;
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W        = 6;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [IDX_W-1:0]               age_t;
    typedef logic [CNT_W-1:0]               count_t;

    // What one cell shows its neighbors: a value, its age and whether it
    // sorts at or below the incoming sample.
    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    le;
    } link_t;

    // Shared control broadcast to every cell.
    typedef struct packed {
        logic en;
        logic full;
        age_t evict_age;
    } cell_ctl_t;

endpackage

### rtl/core/swm_cell.sv
module swm_cell (
    input  logic                clk,
    input  swm_pkg::cell_ctl_t  ctl,
    input  swm_pkg::sample_t    key,
    input  logic                valid,     // cell holds a window sample
    input  logic                rb,        // eviction happens at this or a lower cell
    input  swm_pkg::link_t      right,     // next cell, current contents
    input  swm_pkg::link_t      left,      // previous cell, after removal
    output swm_pkg::link_t      own,
    output swm_pkg::link_t      shifted,
    output logic                evict
);

    swm_pkg::sample_t value_reg;
    swm_pkg::sample_t value_next;
    swm_pkg::age_t    age_reg;
    swm_pkg::age_t    age_next;

    always_comb
    begin
        own.value = value_reg;
        own.age   = age_reg;
        own.le    = valid && ($signed(value_reg) <= $signed(key));
        evict     = valid && ctl.full && (age_reg == ctl.evict_age);
    end

    // Removal closes the gap by pulling from the right.
    always_comb
    begin
        if (rb)
        begin
            shifted = right;
        end
        else
        begin
            shifted = own;
        end
    end

    // Insertion opens a gap by pulling from the left.
    always_comb
    begin
        if (shifted.le)
        begin
            value_next = shifted.value;
            age_next   = shifted.age + swm_pkg::age_t'(1);
        end
        else if (left.le)
        begin
            value_next = key;
            age_next   = '0;
        end
        else
        begin
            value_next = left.value;
            age_next   = left.age + swm_pkg::age_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

### rtl/core/sliding_window_median.sv
// Running lower-median filter over the last window_size signed samples
// (1..32; 0 acts as 1, above 32 acts as 32). One word per clock is accepted
// while the output is drained; a median is flagged pending by the word
// that completes it, then registered for output. The samples sit in a
// sorted row of 32 cells, each with one comparator against the new sample,
// and every word evicts the oldest cell once full and inserts in a single
// neighbor shift, which sets the rate. No output is produced until the
// window is full. tuser high empties the window before its sample; writing
// window_size also empties it. No clearing pass is needed after reset.
module sliding_window_median (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,   // [31:0] sample
    input  logic                     s_axis_tuser,   // [0] restart
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,   // [31:0] median
    input  logic                     cfg_wen,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int N = swm_pkg::WINDOW_MAX;

    logic [swm_pkg::CFG_W-1:0] ws_reg;
    swm_pkg::count_t           fill_reg;
    swm_pkg::count_t           fill_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic                      out_valid_reg;
    swm_pkg::sample_t          out_data_reg;

    swm_pkg::count_t           k;
    swm_pkg::count_t           fill_eff;
    swm_pkg::count_t           fill_after;
    swm_pkg::age_t             mid_idx;
    swm_pkg::sample_t          key;
    swm_pkg::cell_ctl_t        ctl;
    logic                      accept;
    logic                      cap;

    swm_pkg::link_t            own     [N];
    swm_pkg::link_t            shifted [N];
    logic [N-1:0]              ev;
    logic [N-1:0]              rb;
    logic [N-1:0]              cell_valid;
    swm_pkg::sample_t          values  [N];

    always_comb
    begin
        if (ws_reg == '0)
        begin
            k = swm_pkg::count_t'(1);
        end
        else if (ws_reg > swm_pkg::CFG_W'(N))
        begin
            k = swm_pkg::count_t'(N);
        end
        else
        begin
            k = swm_pkg::count_t'(ws_reg);
        end
    end

    assign key      = s_axis_tdata;
    assign cap      = pend_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_reg || cap;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign fill_eff = s_axis_tuser ? '0 : fill_reg;
    assign mid_idx  = swm_pkg::age_t'((k - swm_pkg::count_t'(1)) >> 1);

    always_comb
    begin
        ctl.en        = accept;
        ctl.full      = (fill_eff == k);
        ctl.evict_age = swm_pkg::age_t'(k - swm_pkg::count_t'(1));
        fill_after    = ctl.full ? k : fill_eff + swm_pkg::count_t'(1);
    end

    // a cell pulls from the right when the evicted cell is at or below it
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            cell_valid[j] = (swm_pkg::count_t'(j) < fill_eff);
            rb[j]         = |(ev & ((N'(2) << j) - N'(1)));
        end
    end

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        swm_pkg::link_t right_link;
        swm_pkg::link_t left_link;

        if (j == N - 1)
        begin : g_last
            assign right_link = '0;
        end
        else
        begin : g_mid
            assign right_link = own[j+1];
        end

        if (j == 0)
        begin : g_first
            assign left_link = '{value: '0, age: '0, le: 1'b1};
        end
        else
        begin : g_rest
            assign left_link = shifted[j-1];
        end

        swm_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .key     (key),
            .valid   (cell_valid[j]),
            .rb      (rb[j]),
            .right   (right_link),
            .left    (left_link),
            .own     (own[j]),
            .shifted (shifted[j]),
            .evict   (ev[j])
        );

        assign values[j] = own[j].value;
    end

    always_comb
    begin
        fill_next = fill_reg;
        pend_next = pend_reg;
        if (cfg_wen)
        begin
            fill_next = '0;
        end
        else if (accept)
        begin
            fill_next = fill_after;
        end
        if (accept)
        begin
            pend_next = (fill_after == k);
        end
        else if (cap)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swm_pkg::CFG_W'(3);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                ws_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            pend_reg <= pend_next;
            if (cap)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            out_data_reg <= values[mid_idx];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### rtl/core/swm_check.sv
module swm_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [31:0]               m_axis_tdata
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("median word changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_out_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc, 2))
        else $error("median word without a sample two cycles earlier");

endmodule

bind sliding_window_median swm_check u_swm_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/swm_median_checker.sv
module swm_median_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,
    input  logic                      s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [31:0]               m_axis_tdata,
    input  logic                      cfg_wen,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        pending_medians,
    output int                        medians_checked
);

    import swm_pkg::*;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 3;

    logic [CFG_W-1:0] window_reg;
    sample_t          window_samples[$];
    sample_t          expected_medians[$];

    function automatic int effective_window(logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(w);
    endfunction

    // lower median: the ceil(k/2)-th smallest of the held samples
    function automatic sample_t lower_median();
        sample_t ordered[WINDOW_MAX];
        sample_t v;
        int      n;
        int      j;
        n = window_samples.size();
        for (int i = 0; i < n; i++)
        begin
            v = window_samples[i];
            j = i;
            while (j > 0 && ordered[j-1] > v)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        return ordered[(n - 1) / 2];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t got;
        sample_t want;
        int      k;
        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            window_samples.delete();
            expected_medians.delete();
            fail_count = 0;
            medians_checked = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                window_reg = cfg_wdata;
                window_samples.delete();
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_medians.size() == 0)
                begin
                    $error("median: expected none, got %0d", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    medians_checked++;
                    if (got !== want)
                    begin
                        $error("median: expected %0d, got %0d", want, got);
                        fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                k = effective_window(window_reg);
                if (s_axis_tuser)
                    window_samples.delete();
                if (window_samples.size() >= k)
                    void'(window_samples.pop_front());
                window_samples = {window_samples, sample_t'(s_axis_tdata)};
                if (window_samples.size() == k)
                    expected_medians = {expected_medians, lower_median()};
            end
        end
        pending_medians = expected_medians.size();
    end

endmodule

### sim/sliding_window_median_tb.sv
module sliding_window_median_tb;

    import swm_pkg::*;

    localparam int TOTAL_WORDS  = 1750;
    localparam int IDLE_PCT     = 37;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [31:0]      m_axis_tdata;
    logic             cfg_wen;
    logic [CFG_W-1:0] cfg_wdata;

    int fail_count;
    int pending_medians;
    int medians_checked;

    int words_sent;
    int restarts_sent;
    int window_writes;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_req;

    sliding_window_median u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    swm_median_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_medians (pending_medians),
        .medians_checked (medians_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400_000);
        $display("[sliding_window_median] ERROR");
        $finish;
    end

    // sink side: random backpressure plus a long hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req != 0)
            begin
                rx_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input logic [31:0] smp, input logic restart);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= restart;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
        if (restart)
            restarts_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_medians != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] k);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        window_writes++;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return 32'($signed($urandom_range(15)) - 8);
            4:       return SAMPLE_MAX - $urandom_range(3);
            5:       return SAMPLE_MIN + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_window();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'(WINDOW_MAX);
            2:       return CFG_W'($urandom_range(63, WINDOW_MAX + 1));
            3:       return CFG_W'($urandom_range(WINDOW_MAX - 1, 9));
            default: return CFG_W'($urandom_range(8, 1));
        endcase
    endfunction

    initial
    begin
        int               phase;
        int               run_len;
        int               k_eff;
        logic [CFG_W-1:0] k;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        words_sent    = 0;
        restarts_sent = 0;
        window_writes = 0;
        tx_idle_pct   = IDLE_PCT;
        rx_idle_pct   = IDLE_PCT;
        rx_hold_req   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // window of 3 out of reset: extremes, restart while full and while filling
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b1);
        send_word(32'd1, 1'b1);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        // even window gives the lower middle value
        write_window(CFG_W'(2));
        send_word(32'd10, 1'b0);
        send_word(-32'sd10, 1'b0);
        send_word(32'd10, 1'b0);
        // pass-through, then zero acting as one
        write_window(CFG_W'(1));
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(SAMPLE_MIN, 1'b1);
        write_window('0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);

        phase = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            case (phase)
                0:       k = '1;
                1:       k = CFG_W'(WINDOW_MAX);
                2:       k = CFG_W'(1);
                default: k = pick_window();
            endcase
            write_window(k);
            k_eff = (k == 0) ? 1 : ((k > WINDOW_MAX) ? WINDOW_MAX : int'(k));
            run_len = k_eff + $urandom_range(50, 10);

            if (phase == 2)
            begin
                // long stall on the sink while the source keeps pushing
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                run_len     = 150;
                rx_hold_req = 1;
            end
            else if (phase == 3)
            begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end

            for (int i = 0; i < run_len; i++)
                send_word(pick_sample(), $urandom_range(99) < 3);
            phase++;
        end

        wait_drained();
        repeat (20) @(negedge clk);

        $display("run covered %0d samples (%0d with restart) over %0d window settings",
                 words_sent, restarts_sent, window_writes + 1);
        $display("%0d medians compared, %0d mismatches", medians_checked, fail_count);
        if (fail_count == 0 && pending_medians == 0)
            $display("[sliding_window_median] OK");
        else
            $display("[sliding_window_median] ERROR");
        $finish;
    end

endmodule
